// ===== rtl/exps_pkg.sv =====
// ----------------------------------------------------------------------------
// Exponential-pitch sine oscillator package
// Shared widths, register codes, controller commands and the constant
// exp2 and quarter-wave sine tables.
// ----------------------------------------------------------------------------
package exps_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int EXP_TABLE_BITS  = 8;

    localparam int QUARTER_LEN = (2 ** (SINE_TABLE_BITS - 2)) + 1;
    localparam int EXP_LEN     = 2 ** EXP_TABLE_BITS;
    localparam int QIDX_W      = SINE_TABLE_BITS - 1;

    localparam int KNOB_W  = 15;
    localparam int TICK_W  = 20;
    localparam int CV_W    = 17;
    localparam int SINE_W  = 16;
    localparam int ROM_W   = 15;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KNOB_W-1:0] KNOB_RESET = '0;
    localparam logic [TICK_W-1:0] TICK_RESET = 20'd97391;

    localparam logic signed [17:0] PITCH_MAX  = 18'sd16384;
    localparam logic signed [17:0] PITCH_MIN  = -18'sd16384;
    localparam logic [15:0]        PITCH_SPAN = 16'd32768;
    localparam logic [16:0]        LAMP_BIAS  = 17'd8192;
    localparam logic [8:0]         NOTE_A4    = 9'd440;
    localparam logic [32:0]        RECIP_5    = 33'h0_CCCC_CCCD;
    localparam logic [5:0]         SHIFT_BASE = 6'd34;

    typedef enum logic {
        REG_KNOB = 1'b0,
        REG_TICK = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic capture;
        logic clamp;
        logic mul1;
        logic mul2;
        logic update;
        logic lookup;
        logic out_load;
    } t_dp_cmd;

    typedef logic [EXP_LEN-1:0][31:0]         t_exp_rom;
    typedef logic [QUARTER_LEN-1:0][ROM_W-1:0] t_quarter_rom;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int n = 0; n < 32; n++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int n = 0; n < 32; n++) begin
            if (b != 64'd0) begin
                if (rem >= res + b) begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] one;
        one = 64'd1 << 30;
        x2  = (x * x) >> 30;
        t   = one;
        t   = one - (((x2 * t) >> 30) / 156);
        t   = one - (((x2 * t) >> 30) / 110);
        t   = one - (((x2 * t) >> 30) / 72);
        t   = one - (((x2 * t) >> 30) / 42);
        t   = one - (((x2 * t) >> 30) / 20);
        t   = one - (((x2 * t) >> 30) / 6);
        return (x * t) >> 30;
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] roots [EXP_TABLE_BITS+1];
        logic [63:0] a;
        roots[0] = 64'd1 << 31;
        roots[1] = int_sqrt(64'd1 << 61);
        for (int j = 2; j <= EXP_TABLE_BITS; j++) begin
            roots[j] = int_sqrt(roots[j-1] << 30);
        end
        for (int i = 0; i < EXP_LEN; i++) begin
            a = 64'd1 << 30;
            for (int j = 0; j < EXP_TABLE_BITS; j++) begin
                if (((i >> j) & 1) != 0) begin
                    a = (a * roots[EXP_TABLE_BITS-j] + (64'd1 << 29)) >> 30;
                end
            end
            rom[i] = a[31:0];
        end
        return rom;
    endfunction

    function automatic t_quarter_rom build_quarter_rom();
        t_quarter_rom rom;
        logic [63:0]  x;
        logic [63:0]  e;
        for (int i = 0; i < QUARTER_LEN; i++) begin
            x = (64'd1686629713 * 64'(i)) >> (SINE_TABLE_BITS - 2);
            e = (sin_q30(x) * 64'd20480 + (64'd1 << 29)) >> 30;
            if (e > 64'd20480) begin
                e = 64'd20480;
            end
            rom[i] = e[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam t_exp_rom     EXP_ROM     = build_exp_rom();
    localparam t_quarter_rom QUARTER_ROM = build_quarter_rom();

endpackage

// ===== rtl/exps_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the knob pitch and the tick period.
// ----------------------------------------------------------------------------
module exps_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [exps_pkg::PADDR_W-1:0]      paddr,
    input  logic [exps_pkg::PDATA_W-1:0]      pwdata,
    output logic [exps_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    output logic [exps_pkg::KNOB_W-1:0]       o_knob_pitch,
    output logic [exps_pkg::TICK_W-1:0]       o_tick_period
);
    import exps_pkg::*;

    logic [KNOB_W-1:0] r_knob_pitch;
    logic [TICK_W-1:0] r_tick_period;
    logic              wr_en;
    t_reg_sel          sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = t_reg_sel'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob_pitch  <= KNOB_RESET;
            r_tick_period <= TICK_RESET;
        end else if (wr_en) begin
            unique case (sel)
                REG_KNOB: r_knob_pitch  <= pwdata[KNOB_W-1:0];
                REG_TICK: r_tick_period <= pwdata[TICK_W-1:0];
                default:  r_knob_pitch  <= r_knob_pitch;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_KNOB: prdata = {{(PDATA_W-KNOB_W){r_knob_pitch[KNOB_W-1]}}, r_knob_pitch};
            REG_TICK: prdata = {{(PDATA_W-TICK_W){1'b0}}, r_tick_period};
            default:  prdata = '0;
        endcase
    end

    assign o_knob_pitch  = r_knob_pitch;
    assign o_tick_period = r_tick_period;

endmodule

// ===== rtl/exps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Oscillator controller
// Sequences one request through the datapath steps and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module exps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output exps_pkg::t_dp_cmd o_cmd
);
    import exps_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLAMP  = 7'b0000010,
        S_MUL1   = 7'b0000100,
        S_MUL2   = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_LOOKUP = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_state == S_CLAMP)
        else $error("accepted request did not start the sequence");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_valid)
        else $error("output load did not raise valid");

    a_stall_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && r_out_valid && !i_ready |=> r_state == S_OUT)
        else $error("result overwrote a stalled output");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> r_state == S_OUT && (!r_out_valid || i_ready))
        else $error("output loaded while occupied");

endmodule

// ===== rtl/exps_dp.sv =====
// ----------------------------------------------------------------------------
// Oscillator datapath
// Pitch clamp, exp2 frequency multiply, phase accumulators and the
// quarter-wave sine lookup, stepped by controller commands.
// ----------------------------------------------------------------------------
module exps_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  exps_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [exps_pkg::CV_W-1:0]    i_pitch_cv,
    input  logic [exps_pkg::KNOB_W-1:0]         i_knob_pitch,
    input  logic [exps_pkg::TICK_W-1:0]         i_tick_period,
    output logic signed [exps_pkg::SINE_W-1:0]  o_sine_out,
    output logic                                o_light_on
);
    import exps_pkg::*;

    logic signed [CV_W-1:0]   r_cv;
    logic [15:0]              r_u;
    logic [5:0]               r_shamt;
    logic [39:0]              r_m1;
    logic [36:0]              r_lamp_a;
    logic [59:0]              r_m2;
    logic [22:0]              r_lamp_q;
    logic [31:0]              r_osc_phase;
    logic [31:0]              r_lamp_phase;
    logic signed [SINE_W-1:0] r_sine_res;
    logic                     r_light_res;
    logic signed [SINE_W-1:0] r_sine_out;
    logic                     r_light_on;

    logic signed [17:0]       p_sum;
    logic [17:0]              u_wide;
    logic [15:0]              u_clamped;
    logic [31:0]              exp_val;
    logic [40:0]              mul1_w;
    logic [16:0]              lamp_op;
    logic [36:0]              lamp_w;
    logic [59:0]              mul2_w;
    logic [56:0]              lamp_q_w;
    logic [59:0]              osc_shift;
    logic [1:0]               quad;
    logic [QIDX_W-2:0]        k_raw;
    logic [QIDX_W-1:0]        k_idx;
    logic [SINE_W-1:0]        s_mag;

    assign p_sum  = {{3{i_knob_pitch[KNOB_W-1]}}, i_knob_pitch} + {r_cv[CV_W-1], r_cv};
    assign u_wide = 18'(p_sum - PITCH_MIN);

    always_comb begin
        priority if (p_sum > PITCH_MAX) begin
            u_clamped = PITCH_SPAN;
        end else if (p_sum < PITCH_MIN) begin
            u_clamped = '0;
        end else begin
            u_clamped = u_wide[15:0];
        end
    end

    assign exp_val  = EXP_ROM[r_u[11 -: EXP_TABLE_BITS]];
    assign mul1_w   = 41'(exp_val) * 41'(NOTE_A4);
    assign lamp_op  = {r_u, 1'b0} + LAMP_BIAS;
    assign lamp_w   = 37'(lamp_op) * 37'(i_tick_period);
    assign mul2_w   = 60'(r_m1) * 60'(i_tick_period);
    assign lamp_q_w = 57'(r_lamp_a[36:12]) * 57'(RECIP_5);
    assign osc_shift = r_m2 >> r_shamt;

    assign quad  = r_osc_phase[31:30];
    assign k_raw = r_osc_phase[29 -: (SINE_TABLE_BITS - 2)];
    assign k_idx = quad[0] ? (QIDX_W'(QUARTER_LEN - 1) - {1'b0, k_raw}) : {1'b0, k_raw};
    assign s_mag = {1'b0, QUARTER_ROM[k_idx]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cv <= i_pitch_cv;
        end
        if (i_cmd.clamp) begin
            r_u     <= u_clamped;
            r_shamt <= SHIFT_BASE - {2'b00, u_clamped[15:12]};
        end
        if (i_cmd.mul1) begin
            r_m1     <= mul1_w[39:0];
            r_lamp_a <= lamp_w;
        end
        if (i_cmd.mul2) begin
            r_m2     <= mul2_w;
            r_lamp_q <= lamp_q_w[56:34];
        end
        if (i_cmd.lookup) begin
            r_sine_res  <= quad[1] ? -$signed(s_mag) : $signed(s_mag);
            r_light_res <= !r_lamp_phase[31];
        end
        if (i_cmd.out_load) begin
            r_sine_out <= r_sine_res;
            r_light_on <= r_light_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_phase  <= '0;
            r_lamp_phase <= '0;
        end else if (i_cmd.update) begin
            r_osc_phase  <= r_osc_phase + osc_shift[31:0];
            r_lamp_phase <= r_lamp_phase + {9'd0, r_lamp_q};
        end
    end

    assign o_sine_out = r_sine_out;
    assign o_light_on = r_light_on;

endmodule

// ===== rtl/exp_pitch_sine_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// Exponential-pitch sine oscillator
// Sine oscillator with exponential pitch control and a pitch-rate lamp.
// ----------------------------------------------------------------------------
// Each request on the input channel (i_valid/o_ready) is one sample tick
// carrying a pitch control voltage in volts with 12 fractional bits.
// Each request yields exactly one result on the output channel
// (o_valid/i_ready): a 5 V sine sample and the lamp state.
// The knob pitch and the tick period are set through the APB-style port,
// at byte addresses 0 and 4, while no request is in flight.
// A request is accepted only while the controller is idle. It then runs
// the six-step controller sequence: the pitch clamp, the two chained
// multiplies, the phase update, the sine table read and the output load.
// The result is valid once the output register is loaded, and a new
// request is taken only after the controller has returned to idle.
// The output register holds a result while the receiver stalls, and the
// next request may already be accepted and worked on meanwhile; it then
// waits in its last step until the output register is free.
// Reset clears both phase accumulators and restores the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module exp_pitch_sine_oscillator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [exps_pkg::CV_W-1:0]    i_pitch_cv,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [exps_pkg::SINE_W-1:0]  o_sine_out,
    output logic                                o_light_on,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [exps_pkg::PADDR_W-1:0]        paddr,
    input  logic [exps_pkg::PDATA_W-1:0]        pwdata,
    output logic [exps_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import exps_pkg::*;

    t_dp_cmd           cmd;
    logic [KNOB_W-1:0] knob_pitch;
    logic [TICK_W-1:0] tick_period;

    exps_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_knob_pitch  (knob_pitch),
        .o_tick_period (tick_period)
    );

    exps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    exps_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pitch_cv    (i_pitch_cv),
        .i_knob_pitch  (knob_pitch),
        .i_tick_period (tick_period),
        .o_sine_out    (o_sine_out),
        .o_light_on    (o_light_on)
    );

endmodule

// ===== tb/tb_exp_pitch_sine_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// Exponential-pitch sine oscillator testbench
// Sends sample ticks with random pacing under a sequence of knob pitch and
// tick period settings. Each accepted tick is run through a bit-exact model
// of the phase accumulators and tables, and every sine sample and lamp bit
// that comes out is compared in order with the model.
// ----------------------------------------------------------------------------
module tb_exp_pitch_sine_oscillator_top;
    import exps_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_CAP      = 20;
    localparam int END_CYCLES     = 20;
    localparam int PLANNED        = 5;
    localparam int PHASES         = 9;
    localparam int RANDOM_ITEMS   = 240;

    localparam int KNOB_PLAN [PLANNED] = '{12288, -12288, 16383, -16384, 0};
    localparam int TICK_PLAN [PLANNED] = '{22370, 536871, 1048575, 0, 97391};
    localparam int ITEM_PLAN [PLANNED] = '{180, 180, 40, 40, 200};

    localparam int DIRECTED_CV [25] = '{
        0, 40960, -40960, 65535, -65536, 16384, -16384, 16385, -16385, 4096,
        4095, -4096, 1, -1, 12288, -12288, 32768, -32768, 43690, -43691,
        8192, -8192, 20000, 0, 40960
    };

    typedef struct {
        logic signed [CV_W-1:0] cv;
        int unsigned            gap;
    } t_tick_req;

    typedef struct {
        logic signed [SINE_W-1:0] sine;
        logic                     light;
    } t_osc_sample;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_valid    = 1'b0;
    logic                        o_ready;
    logic signed [CV_W-1:0]      i_pitch_cv = '0;
    logic                        o_valid;
    logic                        i_ready    = 1'b0;
    logic signed [SINE_W-1:0]    o_sine_out;
    logic                        o_light_on;
    logic                        psel       = 1'b0;
    logic                        penable    = 1'b0;
    logic                        pwrite     = 1'b0;
    logic [PADDR_W-1:0]          paddr      = '0;
    logic [PDATA_W-1:0]          pwdata     = '0;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;

    logic [31:0]                 exp_table [EXP_LEN];
    int                          sine_table [QUARTER_LEN];
    logic signed [KNOB_W-1:0]    knob_setting = 15'sd0;
    logic [TICK_W-1:0]           tick_setting = 20'd97391;
    logic [31:0]                 osc_acc  = '0;
    logic [31:0]                 lamp_acc = '0;

    t_tick_req                   tick_backlog [$];
    t_osc_sample                 predicted_samples [$];
    logic                        cv_fire  = 1'b0;
    logic                        res_fire = 1'b0;
    logic                        send_burst = 1'b0;
    logic                        recv_burst = 1'b0;
    int unsigned                 send_wait  = 0;
    int unsigned                 stall_left = 0;
    int                          holds_wanted = 0;
    int                          holds_served = 0;
    int                          idle_cycles  = 0;
    int                          fail_count   = 0;
    int                          ticks_sent   = 0;
    int                          samples_checked = 0;
    int                          settings_used   = 1;

    exp_pitch_sine_oscillator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pitch_cv (i_pitch_cv),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_sine_out (o_sine_out),
        .o_light_on (o_light_on),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic [63:0] taylor_sine(input logic [63:0] x);
        logic [63:0] x_sq;
        logic [63:0] term;
        x_sq = (x * x) >> 30;
        term = 64'd1 << 30;
        for (int n = 6; n >= 1; n--) begin
            term = (64'd1 << 30) - (((x_sq * term) >> 30) / 64'((2 * n) * (2 * n + 1)));
        end
        return (x * term) >> 30;
    endfunction

    function automatic void build_tables();
        logic [63:0] roots [EXP_TABLE_BITS+1];
        logic [63:0] acc;
        logic [63:0] angle;
        roots[0] = 64'd1 << 31;
        roots[1] = floor_sqrt(64'd1 << 61);
        for (int j = 2; j <= EXP_TABLE_BITS; j++) begin
            roots[j] = floor_sqrt(roots[j-1] << 30);
        end
        for (int i = 0; i < EXP_LEN; i++) begin
            acc = 64'd1 << 30;
            for (int j = 0; j < EXP_TABLE_BITS; j++) begin
                if (((i >> j) & 1) != 0) begin
                    acc = (acc * roots[EXP_TABLE_BITS-j] + (64'd1 << 29)) >> 30;
                end
            end
            exp_table[i] = acc[31:0];
        end
        for (int i = 0; i < QUARTER_LEN; i++) begin
            angle = (64'd1686629713 * 64'(i)) >> (SINE_TABLE_BITS - 2);
            acc   = (taylor_sine(angle) * 64'd20480 + (64'd1 << 29)) >> 30;
            sine_table[i] = (acc > 64'd20480) ? 20480 : int'(acc);
        end
    endfunction

    function automatic t_osc_sample advance_oscillator(input logic signed [CV_W-1:0] cv);
        int          pitch;
        int          span;
        int          octave;
        int          level;
        logic [63:0] osc_step;
        logic [63:0] lamp_step;
        logic [1:0]  quadrant;
        logic [8:0]  slot;
        t_osc_sample sample;
        pitch = int'(knob_setting) + int'(cv);
        if (pitch > 16384) begin
            pitch = 16384;
        end
        if (pitch < -16384) begin
            pitch = -16384;
        end
        span     = pitch + 16384;
        octave   = (span >> 12) - 4;
        osc_step = 64'd440 * 64'(exp_table[((span & 4095) >> (12 - EXP_TABLE_BITS))
                   & (EXP_LEN - 1)]) * 64'(tick_setting);
        osc_step = osc_step >> (30 - octave);
        osc_acc  = osc_acc + osc_step[31:0];
        lamp_step = (64'(2 * pitch + 40960) * 64'(tick_setting)) / 64'd20480;
        lamp_acc  = lamp_acc + lamp_step[31:0];
        quadrant = osc_acc[31:30];
        slot = 9'((osc_acc >> (32 - SINE_TABLE_BITS)) & ((1 << (SINE_TABLE_BITS - 2)) - 1));
        if (quadrant[0]) begin
            slot = 9'(QUARTER_LEN - 1) - slot;
        end
        level = sine_table[slot];
        if (quadrant[1]) begin
            level = -level;
        end
        sample.sine  = SINE_W'(level);
        sample.light = ~lamp_acc[31];
        return sample;
    endfunction

    function automatic logic signed [CV_W-1:0] random_cv();
        int unsigned pick;
        int          v;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            v = int'($urandom_range(0, 81920)) - 40960;
        end else if (pick < 85) begin
            v = ((pick % 2 == 0) ? 16384 : -16384) - int'(knob_setting)
                + int'($urandom_range(0, 600)) - 300;
        end else begin
            v = int'($urandom);
        end
        return CV_W'(v);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic queue_tick(input logic signed [CV_W-1:0] cv);
        t_tick_req req;
        req.cv  = cv;
        req.gap = send_burst ? 0 : $urandom_range(0, 6);
        tick_backlog.push_back(req);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (tick_backlog.size() != 0 || i_valid || predicted_samples.size() != 0);
    endtask

    task automatic write_register(input t_reg_sel sel, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (sel == REG_KNOB) begin
            knob_setting = data[KNOB_W-1:0];
        end else begin
            tick_setting = data[TICK_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sender: a request stays up until taken, then the next one follows its gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || cv_fire) begin
            if (tick_backlog.size() != 0 && send_wait >= tick_backlog[0].gap) begin
                i_valid    <= 1'b1;
                i_pitch_cv <= tick_backlog[0].cv;
                void'(tick_backlog.pop_front());
                send_wait = 0;
            end else begin
                i_valid <= 1'b0;
                if (tick_backlog.size() != 0) begin
                    send_wait++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (holds_served != holds_wanted) begin
                holds_served++;
                stall_left = LONG_HOLD;
            end else if (res_fire && !recv_burst) begin
                stall_left = $urandom_range(0, 6);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_osc_sample want;
        cv_fire  <= i_rst_n && i_valid && o_ready;
        res_fire <= i_rst_n && o_valid && i_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (predicted_samples.size() == 0) begin
                    flag_mismatch($sformatf("sample %0d / lamp %0b with none pending",
                                            o_sine_out, o_light_on));
                end else begin
                    want = predicted_samples.pop_front();
                    if (o_sine_out !== want.sine) begin
                        flag_mismatch($sformatf("sample %0d: sine %0d, want %0d",
                                                samples_checked, o_sine_out, want.sine));
                    end
                    if (o_light_on !== want.light) begin
                        flag_mismatch($sformatf("sample %0d: lamp %0b, want %0b",
                                                samples_checked, o_light_on, want.light));
                    end
                    samples_checked++;
                end
            end
            if (i_valid && o_ready) begin
                predicted_samples.push_back(advance_oscillator(i_pitch_cv));
                ticks_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int knob;
        int tick;
        int count;
        build_tables();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_CV[n]) begin
            queue_tick(CV_W'(DIRECTED_CV[n]));
        end
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < PLANNED) begin
                knob  = KNOB_PLAN[ph];
                tick  = TICK_PLAN[ph];
                count = ITEM_PLAN[ph];
            end else begin
                knob  = int'($urandom_range(0, 24576)) - 12288;
                tick  = int'($urandom_range(22370, 536871));
                count = RANDOM_ITEMS;
            end
            // Upper bits of the write data are junk; only the field bits may land.
            write_register(REG_KNOB, ($urandom & 32'hFFFF_8000) | (32'(knob) & 32'h0000_7FFF));
            write_register(REG_TICK, ($urandom & 32'hFFF0_0000) | (32'(tick) & 32'h000F_FFFF));
            settings_used++;
            send_burst = (ph == 1 || ph == 4);
            recv_burst = (ph == 4);
            if (ph == 1) begin
                holds_wanted++;
            end
            for (int n = 0; n < count; n++) begin
                queue_tick(random_cv());
            end
            wait_idle();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (predicted_samples.size() != 0) begin
            flag_mismatch($sformatf("%0d samples never arrived", predicted_samples.size()));
        end
        $display("summary: %0d ticks sent and %0d samples compared under %0d register settings",
                 ticks_sent, samples_checked, settings_used);
        $display("summary: pitch clamping, oversized and zero tick periods, long output stall");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
